[sv/nab_pkg.sv]
// ---------------------------------------------------------------------------
// nab_pkg: shared types, constants and functions of the nibble block cipher
// 4-bit s-box, gf(16) doubling, round function and one key schedule step
// ---------------------------------------------------------------------------
package nab_pkg;

  localparam int unsigned BlockWidth  = 64;
  localparam int unsigned NibbleCount = 16;
  localparam int unsigned RconCount   = 10;

  // reduction x^4 + x + 1 folds the carried-out bit back as 4'b0011
  localparam logic [3:0] ReduceConst = 4'h3;

  localparam logic [3:0] SBOX [16] = '{
    4'h6, 4'hb, 4'h5, 4'h4, 4'h2, 4'he, 4'h7, 4'ha,
    4'h9, 4'hd, 4'hf, 4'hc, 4'h3, 4'h1, 4'h0, 4'h8
  };

  localparam logic [3:0] RCON [10] = '{
    4'd1, 4'd2, 4'd4, 4'd8, 4'd3, 4'd6, 4'd12, 4'd11, 4'd5, 4'd10
  };

  typedef logic [BlockWidth-1:0] nab_block_t;

  // one pipeline stage: valid bit, cipher state and the round key of that stage
  typedef struct packed {
    logic       valid;
    nab_block_t state;
    nab_block_t rkey;
  } nab_stage_t;

  function automatic logic [3:0] sbox(input logic [3:0] x);
    return SBOX[x];
  endfunction

  function automatic logic [3:0] gf_double(input logic [3:0] x);
    return {x[2:0], 1'b0} ^ (x[3] ? ReduceConst : 4'h0);
  endfunction

  // round constant of round rnd, zero past the end of the table
  function automatic logic [3:0] rcon_of(input int unsigned rnd);
    logic [3:0] rc;
    rc = 4'h0;
    if (rnd >= 1 && rnd <= RconCount) begin
      rc = RCON[4'(rnd-1)];
    end
    return rc;
  endfunction

  // s-box, row rotation and column mixing; nibble 4c+r is row r, column c
  function automatic nab_block_t round_fn(input nab_block_t st);
    nab_block_t sub;
    nab_block_t shf;
    nab_block_t mix;
    logic [3:0] a0, a1, a2, a3, all;
    sub = '0;
    shf = '0;
    mix = '0;
    for (int k = 0; k < NibbleCount; k++) begin
      sub[63-4*k -: 4] = sbox(st[63-4*k -: 4]);
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        shf[63-4*(4*c+r) -: 4] = sub[63-4*(4*((c+r)%4)+r) -: 4];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0  = shf[63-16*c -: 4];
      a1  = shf[59-16*c -: 4];
      a2  = shf[55-16*c -: 4];
      a3  = shf[51-16*c -: 4];
      all = a0 ^ a1 ^ a2 ^ a3;
      mix[63-16*c -: 4] = a0 ^ all ^ gf_double(a0 ^ a1);
      mix[59-16*c -: 4] = a1 ^ all ^ gf_double(a1 ^ a2);
      mix[55-16*c -: 4] = a2 ^ all ^ gf_double(a2 ^ a3);
      mix[51-16*c -: 4] = a3 ^ all ^ gf_double(a3 ^ a0);
    end
    return mix;
  endfunction

  // next four schedule words from the previous four
  function automatic nab_block_t key_step(input nab_block_t rk, input logic [3:0] rc);
    logic [15:0] w0, w1, w2, w3, t, n0, n1, n2, n3;
    w0 = rk[63:48];
    w1 = rk[47:32];
    w2 = rk[31:16];
    w3 = rk[15:0];
    t  = {sbox(w3[11:8]) ^ rc, sbox(w3[7:4]), sbox(w3[3:0]), sbox(w3[15:12])};
    n0 = w0 ^ t;
    n1 = w1 ^ n0;
    n2 = w2 ^ n1;
    n3 = w3 ^ n2;
    return {n0, n1, n2, n3};
  endfunction

endpackage

[sv/nab_round.sv]
// ---------------------------------------------------------------------------
// nab_round: one registered cipher round
// round function plus key xor, with the round key derived alongside
// ---------------------------------------------------------------------------
module nab_round #(
  parameter int unsigned RND = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  nab_pkg::nab_stage_t stg_in,
  output nab_pkg::nab_stage_t stg_out
);
  import nab_pkg::*;

  localparam logic [3:0] RoundConst = rcon_of(RND);

  logic       valid_r;
  nab_block_t state_r;
  nab_block_t rkey_r;
  nab_block_t rkey_nxt;
  nab_block_t state_nxt;

  always_comb begin
    rkey_nxt  = key_step(stg_in.rkey, RoundConst);
    state_nxt = round_fn(stg_in.state) ^ rkey_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= stg_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    state_r <= state_nxt;
    rkey_r  <= rkey_nxt;
  end

  assign stg_out = '{valid: valid_r, state: state_r, rkey: rkey_r};

endmodule

[sv/nibble_aes_block_encrypt.sv]
// ---------------------------------------------------------------------------
// nibble_aes_block_encrypt: pipelined 64-bit nibble cipher over gf(16)
// key whitening then ROUNDS rounds of s-box, row rotation, mixing, key xor
// ---------------------------------------------------------------------------
// channel   ports                          transfer
// input     start, busy, in_*              start high and busy low at clk edge
// result    out_valid, out_*               one-cycle strobe, always taken
// config    cfg_valid, cfg_ready, cfg_*    cfg_valid and cfg_ready high
//
// the pipe has one whitening stage and one stage per round
// a new block can start every cycle; busy stays low, the pipe never stalls
// each round stage derives its own round key, so nothing is precomputed
// synchronous active-low reset clears valid bits and the key (to zero)
// rewrite the key only with no transaction in flight
// ---------------------------------------------------------------------------
module nibble_aes_block_encrypt #(
  parameter int unsigned ROUNDS = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 start,
  output logic                 busy,
  input  nab_pkg::nab_block_t  in_plaintext_block,
  // key write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  nab_pkg::nab_block_t  cfg_cipher_key,
  // result channel
  output logic                 out_valid,
  output nab_pkg::nab_block_t  out_ciphertext_block
);
  import nab_pkg::*;

  // key register
  nab_block_t key_r;

  // whitening stage registers
  logic       wht_valid_r;
  nab_block_t wht_state_r;
  nab_block_t wht_key_r;

  // stage bundles, index 0 is whitening, index i is after round i
  nab_stage_t stg [ROUNDS+1];

  logic accept;
  logic cfg_write;

  // the pipe never holds off, so inputs and key writes are always taken
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_write) begin
      key_r <= cfg_cipher_key;
    end
  end

  // whitening: round key 0 is the key itself
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wht_valid_r <= 1'b0;
    end else begin
      wht_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    wht_state_r <= in_plaintext_block ^ key_r;
    wht_key_r   <= key_r;
  end

  assign stg[0] = '{valid: wht_valid_r, state: wht_state_r, rkey: wht_key_r};

  // one registered stage per round
  for (genvar i = 1; i <= ROUNDS; i++) begin : g_round
    nab_round #(
      .RND (i)
    ) u_round (
      .clk     (clk),
      .rst_n   (rst_n),
      .stg_in  (stg[i-1]),
      .stg_out (stg[i])
    );
  end

  assign out_valid            = stg[ROUNDS].valid;
  assign out_ciphertext_block = stg[ROUNDS].state;

`ifndef NO_ASSERTIONS
  // every result comes from a transaction taken through the whitening stage and every round stage
  a_out_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, ROUNDS + 1))
    else $error("result strobe without a matching input transaction");

  // no accepted transaction is lost in the pipe
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##(ROUNDS + 1) out_valid)
    else $error("accepted transaction produced no result");

  // whitening stage holds plaintext xor key of the accepting cycle
  a_whitening: assert property (@(posedge clk) disable iff (!rst_n)
    wht_valid_r |-> wht_state_r == ($past(in_plaintext_block) ^ $past(key_r)))
    else $error("whitening stage mismatch");

  // key only moves on a write transaction
  a_key_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_write |=> $stable(key_r))
    else $error("key changed without a write");
`endif

endmodule
